// ----- rtl/rcfr_pkg.sv -----
package rcfr_pkg;

   // Payload widths
   localparam int BYTE_W = 8;
   localparam int EVENT_W = 3;
   localparam int LEN_W = 12;
   localparam int INDEX_W = 11;
   localparam int HEADER_BYTES = 5;

   // Result event codes
   localparam logic [EVENT_W-1:0] EV_NONE = 3'd0;
   localparam logic [EVENT_W-1:0] EV_CHUNK_ACCEPTED = 3'd1;
   localparam logic [EVENT_W-1:0] EV_FRAME_COMPLETE = 3'd2;
   localparam logic [EVENT_W-1:0] EV_PACKET_IGNORED = 3'd3;
   localparam logic [EVENT_W-1:0] EV_ORDER_ABORT = 3'd4;
   localparam logic [EVENT_W-1:0] EV_OVERFLOW_ABORT = 3'd5;

   // Input beat commands
   localparam logic CMD_RX_BYTE = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // Header byte positions
   localparam logic [2:0] HDR_TYPE = 3'd0;
   localparam logic [2:0] HDR_SEQ = 3'd1;
   localparam logic [2:0] HDR_INDEX = 3'd2;
   localparam logic [2:0] HDR_COUNT = 3'd3;
   localparam logic [2:0] HDR_DLEN = 3'd4;

endpackage

// ----- rtl/rcfr_ifs.sv -----
// Request channel: received packet bytes and frame store reads
interface rcfr_req_if;
   logic                             valid;
   logic                             ready;
   logic                             cmd;
   logic [rcfr_pkg::BYTE_W-1:0]      rx_byte;
   logic                             packet_first;
   logic                             packet_last;
   logic [rcfr_pkg::INDEX_W-1:0]     read_index;

   modport source (output valid, cmd, rx_byte, packet_first, packet_last, read_index,
                   input ready);
   modport sink (input valid, cmd, rx_byte, packet_first, packet_last, read_index,
                 output ready);
endinterface

// Response channel: one result per request beat
interface rcfr_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [rcfr_pkg::EVENT_W-1:0]     event_res;
   logic [rcfr_pkg::LEN_W-1:0]       frame_len;
   logic [rcfr_pkg::BYTE_W-1:0]      read_data;
   logic                             assembling;

   modport source (output valid, event_res, frame_len, read_data, assembling,
                   input ready);
   modport sink (input valid, event_res, frame_len, read_data, assembling,
                 output ready);
endinterface

// Register write channel: accepted packet type
interface rcfr_csr_if;
   logic                             valid;
   logic                             ready;
   logic [rcfr_pkg::BYTE_W-1:0]      data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ----- rtl/rcfr_ram.sv -----
// Simple dual-port RAM, one write and one registered read per cycle
module rcfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/radio_chunk_frame_reassembler_core.sv -----
// Radio chunk frame reassembler. Packet bytes (cmd 0) are taken one per cycle
// while the response channel is not stalled; header bytes land in registers and
// data bytes in a staging RAM. For the beat that carries the last-byte mark,
// ST_EVAL checks the header, and if it passes the staged chunk is copied into
// the frame store one byte per cycle through the staging RAM read port. A frame
// store read (cmd 0 clear, cmd 1) goes through the registered RAM read. Each beat
// gives one response; a new beat is taken while the previous response still
// waits, as long as the response register is free by the next edge. The frame
// store is never swept after reset: a high-water mark of written bytes makes
// every position not yet written read as zero, so the block is ready right
// after reset. The accepted-type register is always writable.
module radio_chunk_frame_reassembler_core #(
   parameter int DATA_BYTES = 128,
   parameter int MIN_PACKET_BYTES = 133,
   parameter int FRAME_BYTES = 2048
) (
   input  logic              clock,
   input  logic              reset,
   rcfr_req_if.sink          req_chan,
   rcfr_rsp_if.source        rsp_chan,
   rcfr_csr_if.sink          csr_chan
);

   localparam int FW = $clog2(FRAME_BYTES + 1);
   localparam int AW = $clog2(FRAME_BYTES);
   localparam int SAW = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;
   localparam int CW = (FW > rcfr_pkg::INDEX_W) ? FW : rcfr_pkg::INDEX_W;
   localparam int BW = rcfr_pkg::BYTE_W;

   // Sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_EVAL = 2'd2;
   localparam logic [1:0] ST_COPY = 2'd3;

   logic [1:0]                   state_ff, state_in;
   logic [BW-1:0]                acc_type_ff, acc_type_in;
   logic [BW-1:0]                hdr_ff [rcfr_pkg::HEADER_BYTES];
   logic [BW-1:0]                hdr_in [rcfr_pkg::HEADER_BYTES];
   logic [BW-1:0]                pkt_cnt_ff, pkt_cnt_in;
   logic                         in_prog_ff, in_prog_in;
   logic [BW-1:0]                exp_seq_ff, exp_seq_in;
   logic [BW-1:0]                exp_chunk_ff, exp_chunk_in;
   logic [FW-1:0]                fill_ff, fill_in;
   logic [FW-1:0]                hwm_ff, hwm_in;
   logic [BW-1:0]                cnt_ff, cnt_in;
   logic [AW-1:0]                fa_ff, fa_in;
   logic                         wr_valid_ff, wr_valid_in;
   logic [AW-1:0]                wr_addr_ff, wr_addr_in;
   logic [rcfr_pkg::EVENT_W-1:0] ev_pend_ff, ev_pend_in;
   logic                         rd_ok_ff, rd_ok_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [rcfr_pkg::EVENT_W-1:0] rsp_event_ff, rsp_event_in;
   logic [rcfr_pkg::LEN_W-1:0]   rsp_len_ff, rsp_len_in;
   logic [BW-1:0]                rsp_data_ff, rsp_data_in;
   logic                         rsp_asm_ff, rsp_asm_in;

   logic                         req_fire;
   logic [BW-1:0]                pos;
   logic [BW:0]                  stage_off;

   logic                         st_we;
   logic [SAW-1:0]               st_waddr;
   logic [SAW-1:0]               st_raddr;
   logic [BW-1:0]                st_rdata;
   logic [BW-1:0]                fs_rdata;

   logic                         bad_pkt;
   logic                         start_chunk;
   logic                         order_bad;
   logic [FW-1:0]                base;
   logic [FW:0]                  sum;
   logic                         overflow;
   logic                         complete;

   // Handshakes
   assign req_chan.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.event_res = rsp_event_ff;
   assign rsp_chan.frame_len = rsp_len_ff;
   assign rsp_chan.read_data = rsp_data_ff;
   assign rsp_chan.assembling = rsp_asm_ff;

   // Byte position within the current packet
   assign pos = req_chan.packet_first ? '0 : pkt_cnt_ff;
   assign stage_off = {1'b0, pos} - (BW+1)'(rcfr_pkg::HEADER_BYTES);
   assign st_waddr = SAW'(stage_off);
   assign st_raddr = SAW'(cnt_ff);

   // Packet checks on the registered header
   assign bad_pkt = ({1'b0, pkt_cnt_ff} < (BW+1)'(MIN_PACKET_BYTES))
                    || (hdr_ff[rcfr_pkg::HDR_TYPE] != acc_type_ff)
                    || (hdr_ff[rcfr_pkg::HDR_DLEN] == '0)
                    || ({1'b0, hdr_ff[rcfr_pkg::HDR_DLEN]} > (BW+1)'(DATA_BYTES));
   assign start_chunk = (hdr_ff[rcfr_pkg::HDR_INDEX] == '0);
   assign order_bad = !start_chunk && (!in_prog_ff
                      || (hdr_ff[rcfr_pkg::HDR_SEQ] != exp_seq_ff)
                      || (hdr_ff[rcfr_pkg::HDR_INDEX] != exp_chunk_ff));
   assign base = start_chunk ? '0 : fill_ff;
   assign sum = {1'b0, base} + (FW+1)'(hdr_ff[rcfr_pkg::HDR_DLEN]);
   assign overflow = sum > (FW+1)'(FRAME_BYTES);
   assign complete = ({1'b0, hdr_ff[rcfr_pkg::HDR_INDEX]} + 9'd1)
                     == {1'b0, hdr_ff[rcfr_pkg::HDR_COUNT]};

   // Next-state logic
   always_comb begin
      state_in = state_ff;
      acc_type_in = csr_chan.valid ? csr_chan.data : acc_type_ff;
      hdr_in = hdr_ff;
      pkt_cnt_in = pkt_cnt_ff;
      in_prog_in = in_prog_ff;
      exp_seq_in = exp_seq_ff;
      exp_chunk_in = exp_chunk_ff;
      fill_in = fill_ff;
      hwm_in = hwm_ff;
      cnt_in = cnt_ff;
      fa_in = fa_ff;
      wr_valid_in = 1'b0;
      wr_addr_in = wr_addr_ff;
      ev_pend_in = ev_pend_ff;
      rd_ok_in = rd_ok_ff;
      st_we = 1'b0;

      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_event_in = rsp_event_ff;
      rsp_len_in = rsp_len_ff;
      rsp_data_in = rsp_data_ff;
      rsp_asm_in = rsp_asm_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.cmd == rcfr_pkg::CMD_READ) begin
                  rd_ok_in = CW'(req_chan.read_index) < CW'(hwm_ff);
                  state_in = ST_READ;
               end else begin
                  pkt_cnt_in = (pos != '1) ? pos + 8'd1 : pos;
                  if (pos < BW'(rcfr_pkg::HEADER_BYTES)) begin
                     hdr_in[pos[2:0]] = req_chan.rx_byte;
                  end else if (stage_off < (BW+1)'(DATA_BYTES)) begin
                     st_we = 1'b1;
                  end
                  if (req_chan.packet_last) begin
                     state_in = ST_EVAL;
                  end else begin
                     rsp_valid_in = 1'b1;
                     rsp_event_in = rcfr_pkg::EV_NONE;
                     rsp_len_in = '0;
                     rsp_data_in = '0;
                     rsp_asm_in = in_prog_ff;
                  end
               end
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_event_in = rcfr_pkg::EV_NONE;
            rsp_len_in = '0;
            rsp_data_in = rd_ok_ff ? fs_rdata : '0;
            rsp_asm_in = in_prog_ff;
            state_in = ST_IDLE;
         end
         ST_EVAL: begin
            rsp_len_in = '0;
            rsp_data_in = '0;
            if (bad_pkt) begin
               rsp_valid_in = 1'b1;
               rsp_event_in = rcfr_pkg::EV_PACKET_IGNORED;
               rsp_asm_in = in_prog_ff;
               state_in = ST_IDLE;
            end else if (order_bad) begin
               in_prog_in = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_event_in = rcfr_pkg::EV_ORDER_ABORT;
               rsp_asm_in = 1'b0;
               state_in = ST_IDLE;
            end else begin
               // New frame start resets the frame tracking
               if (start_chunk) begin
                  exp_seq_in = hdr_ff[rcfr_pkg::HDR_SEQ];
                  exp_chunk_in = '0;
                  fill_in = '0;
               end
               if (overflow) begin
                  in_prog_in = 1'b0;
                  rsp_valid_in = 1'b1;
                  rsp_event_in = rcfr_pkg::EV_OVERFLOW_ABORT;
                  rsp_asm_in = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  fill_in = sum[FW-1:0];
                  hwm_in = (sum[FW-1:0] > hwm_ff) ? sum[FW-1:0] : hwm_ff;
                  exp_chunk_in = (start_chunk ? '0 : exp_chunk_ff) + 8'd1;
                  in_prog_in = !complete;
                  ev_pend_in = complete ? rcfr_pkg::EV_FRAME_COMPLETE
                                        : rcfr_pkg::EV_CHUNK_ACCEPTED;
                  fa_in = AW'(base);
                  cnt_in = '0;
                  state_in = ST_COPY;
               end
            end
         end
         ST_COPY: begin
            // One staged byte read per cycle, written in the next cycle
            if (cnt_ff != hdr_ff[rcfr_pkg::HDR_DLEN]) begin
               wr_valid_in = 1'b1;
               wr_addr_in = fa_ff;
               fa_in = fa_ff + AW'(1);
               cnt_in = cnt_ff + 8'd1;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_event_in = ev_pend_ff;
               rsp_len_in = (ev_pend_ff == rcfr_pkg::EV_FRAME_COMPLETE)
                            ? rcfr_pkg::LEN_W'(fill_ff) : '0;
               rsp_data_in = '0;
               rsp_asm_in = in_prog_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         acc_type_ff <= 8'd1;
         hdr_ff <= '{default: '0};
         pkt_cnt_ff <= '0;
         in_prog_ff <= 1'b0;
         exp_seq_ff <= '0;
         exp_chunk_ff <= '0;
         fill_ff <= '0;
         hwm_ff <= '0;
         wr_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         acc_type_ff <= acc_type_in;
         hdr_ff <= hdr_in;
         pkt_cnt_ff <= pkt_cnt_in;
         in_prog_ff <= in_prog_in;
         exp_seq_ff <= exp_seq_in;
         exp_chunk_ff <= exp_chunk_in;
         fill_ff <= fill_in;
         hwm_ff <= hwm_in;
         wr_valid_ff <= wr_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      fa_ff <= fa_in;
      wr_addr_ff <= wr_addr_in;
      ev_pend_ff <= ev_pend_in;
      rd_ok_ff <= rd_ok_in;
      rsp_event_ff <= rsp_event_in;
      rsp_len_ff <= rsp_len_in;
      rsp_data_ff <= rsp_data_in;
      rsp_asm_ff <= rsp_asm_in;
   end

   // Staging RAM for the data bytes of the packet in flight
   rcfr_ram #(
      .WIDTH (BW),
      .DEPTH (DATA_BYTES)
   ) u_stage_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (req_chan.rx_byte),
      .rd_addr (st_raddr),
      .rd_data (st_rdata)
   );

   // Frame store
   rcfr_ram #(
      .WIDTH (BW),
      .DEPTH (FRAME_BYTES)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (wr_valid_ff),
      .wr_addr (wr_addr_ff),
      .wr_data (st_rdata),
      .rd_addr (AW'(req_chan.read_index)),
      .rd_data (fs_rdata)
   );

endmodule

// ----- rtl/rcfr_checker.sv -----
// Port-level checks on the reassembler response stream
module rcfr_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [rcfr_pkg::EVENT_W-1:0]     rsp_event_res,
   input logic [rcfr_pkg::LEN_W-1:0]       rsp_frame_len,
   input logic [rcfr_pkg::BYTE_W-1:0]      rsp_read_data,
   input logic                             rsp_assembling
);

   // No response right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_res)
         && $stable(rsp_frame_len) && $stable(rsp_read_data) && $stable(rsp_assembling))
      else $error("stalled response changed");

   // Event code within the defined set
   a_event_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_event_res <= rcfr_pkg::EV_OVERFLOW_ABORT)
      else $error("undefined event code");

   // Frame length only reported on completion
   a_len_only_complete: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res != rcfr_pkg::EV_FRAME_COMPLETE |-> rsp_frame_len == '0)
      else $error("frame length without completion");

   // Completion and aborts end the reassembly
   a_end_clears_asm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res == rcfr_pkg::EV_FRAME_COMPLETE
         || rsp_event_res == rcfr_pkg::EV_ORDER_ABORT
         || rsp_event_res == rcfr_pkg::EV_OVERFLOW_ABORT) |-> !rsp_assembling)
      else $error("assembling still set after frame end");

endmodule

bind radio_chunk_frame_reassembler_core rcfr_checker u_rcfr_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_event_res  (rsp_chan.event_res),
   .rsp_frame_len  (rsp_chan.frame_len),
   .rsp_read_data  (rsp_chan.read_data),
   .rsp_assembling (rsp_chan.assembling)
);
